// ----- rtl/mch_pkg.sv -----
// ----------------------------------------------------------------------------
// mch_pkg
// Types and codes shared by the monotone chain convex hull block.
// ----------------------------------------------------------------------------
package mch_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 16;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FEW  = 2'd1;
	localparam logic [1:0] STAT_OVFL = 2'd2;

	typedef struct packed {
		logic               req_type;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
		logic [9:0]         index;
	} req_t;

	typedef struct packed {
		logic [10:0]        hull_count;
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic               index_ok;
		logic [1:0]         status;
	} res_t;

endpackage

// ----- rtl/mch_cross.sv -----
// ----------------------------------------------------------------------------
// mch_cross
// Three-stage orientation test: flags (b-a) x (c-a) <= 0.
// ----------------------------------------------------------------------------
module mch_cross #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [2*COORD_BITS-1:0] pa,
	input  logic [2*COORD_BITS-1:0] pb,
	input  logic [2*COORD_BITS-1:0] pc,
	output logic                    done,
	output logic                    nonpos
);
	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int MW = 2 * CB + 2;

	logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
	logic signed [DW-1:0] dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [MW-1:0] p1_s2, p2_s2;
	logic                 v_s1, v_s2, v_s3;
	logic                 np_s3;

	assign ax = signed'(pa[2*CB-1 -: CB]);
	assign ay = signed'(pa[CB-1:0]);
	assign bx = signed'(pb[2*CB-1 -: CB]);
	assign by = signed'(pb[CB-1:0]);
	assign cx = signed'(pc[2*CB-1 -: CB]);
	assign cy = signed'(pc[CB-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx1_s1 <= DW'(bx) - DW'(ax);
		dy1_s1 <= DW'(by) - DW'(ay);
		dx2_s1 <= DW'(cx) - DW'(ax);
		dy2_s1 <= DW'(cy) - DW'(ay);
		p1_s2  <= MW'(dx1_s1) * MW'(dy2_s1);
		p2_s2  <= MW'(dy1_s1) * MW'(dx2_s1);
		np_s3  <= (p1_s2 <= p2_s2);
	end

	assign done   = v_s3;
	assign nonpos = np_s3;

endmodule

// ----- rtl/mch_core.sv -----
// ----------------------------------------------------------------------------
// mch_core
// Point, stack and hull memories with the load, sort, chain and copy sequencer.
// ----------------------------------------------------------------------------
module mch_core #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  mch_pkg::req_t req,
	output logic          req_ready,
	output logic          res_valid,
	output mch_pkg::res_t res,
	input  logic          res_take
);
	import mch_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = AW + 2;
	localparam int PW  = $clog2(2 * MAX_POINTS);
	localparam int TW  = PW + 1;
	localparam int PTW = 2 * CB;
	localparam int HW  = $clog2(MAX_POINTS + 1);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_RES  = 5'd1;
	localparam logic [4:0] ST_RD   = 5'd2;
	localparam logic [4:0] ST_SSEG = 5'd3;
	localparam logic [4:0] ST_SRD  = 5'd4;
	localparam logic [4:0] ST_SCMP = 5'd5;
	localparam logic [4:0] ST_U0   = 5'd6;
	localparam logic [4:0] ST_U1   = 5'd7;
	localparam logic [4:0] ST_U2   = 5'd8;
	localparam logic [4:0] ST_PRD  = 5'd9;
	localparam logic [4:0] ST_PWT  = 5'd10;
	localparam logic [4:0] ST_X0   = 5'd11;
	localparam logic [4:0] ST_XW   = 5'd12;
	localparam logic [4:0] ST_SR   = 5'd13;
	localparam logic [4:0] ST_SW   = 5'd14;
	localparam logic [4:0] ST_PW2  = 5'd15;
	localparam logic [4:0] ST_PUSH = 5'd16;
	localparam logic [4:0] ST_L0   = 5'd17;
	localparam logic [4:0] ST_L1   = 5'd18;
	localparam logic [4:0] ST_L2   = 5'd19;
	localparam logic [4:0] ST_CS   = 5'd20;
	localparam logic [4:0] ST_C0   = 5'd21;
	localparam logic [4:0] ST_C1   = 5'd22;
	localparam logic [4:0] ST_C2   = 5'd23;

	logic [PTW-1:0] mem_a [MAX_POINTS];
	logic [PTW-1:0] mem_b [MAX_POINTS];
	logic [PTW-1:0] mem_h [MAX_POINTS];
	logic [AW-1:0]  mem_s [2*MAX_POINTS];

	logic           a_we, b_we, h_we, s_we;
	logic [AW-1:0]  a_wa, b_wa, h_wa, h_ra, ra0, ra1;
	logic [PTW-1:0] a_wd, b_wd, h_wd;
	logic [PTW-1:0] a_rd0, a_rd1, b_rd0, b_rd1, h_rd;
	logic [PW-1:0]  s_wa, s_ra;
	logic [AW-1:0]  s_wd, s_rd;

	logic [4:0]     state_q;
	logic [HW-1:0]  loaded_q, hs_q, hs_tmp_q;
	logic           ovf_q, ok_q, sel_q, upper_q;
	logic [1:0]     st_q;
	logic [CW-1:0]  n_q, w_q, lo_q, mid_q, hi_q, i_q, j_q, k_q;
	logic [TW-1:0]  top_q, base_q;
	logic [AW-1:0]  ia_q, ib_q, ic_q;
	logic [PTW-1:0] pa_q, pb_q, pc_q;
	res_t           res_q;

	logic [PTW-1:0] src0, src1, pt_in;
	logic           take_a, x_start, x_done, x_nonpos;
	logic           room, ovf_n;
	logic [HW-1:0]  loaded_n;
	logic [1:0]     st_n;
	logic [CW-1:0]  seg_mid, seg_hi, w2;

	always_ff @(posedge clk) begin
		if (a_we) mem_a[a_wa] <= a_wd;
		a_rd0 <= mem_a[ra0];
		a_rd1 <= mem_a[ra1];
	end

	always_ff @(posedge clk) begin
		if (b_we) mem_b[b_wa] <= b_wd;
		b_rd0 <= mem_b[ra0];
		b_rd1 <= mem_b[ra1];
	end

	always_ff @(posedge clk) begin
		if (h_we) mem_h[h_wa] <= h_wd;
		h_rd <= mem_h[h_ra];
	end

	always_ff @(posedge clk) begin
		if (s_we) mem_s[s_wa] <= s_wd;
		s_rd <= mem_s[s_ra];
	end

	assign src0  = sel_q ? b_rd0 : a_rd0;
	assign src1  = sel_q ? b_rd1 : a_rd1;
	assign pt_in = {CB'($unsigned(req.x)), CB'($unsigned(req.y))};

	assign take_a = (i_q < mid_q) && ((j_q >= hi_q) ||
		(signed'(src0[PTW-1 -: CB]) < signed'(src1[PTW-1 -: CB])) ||
		((src0[PTW-1 -: CB] == src1[PTW-1 -: CB]) &&
		 (signed'(src0[CB-1:0]) <= signed'(src1[CB-1:0]))));

	assign room     = loaded_q < HW'(MAX_POINTS);
	assign ovf_n    = ovf_q | ~room;
	assign loaded_n = loaded_q + HW'(room);
	assign st_n     = ovf_n ? STAT_OVFL : STAT_OK;
	assign seg_mid  = (lo_q + w_q < n_q) ? lo_q + w_q : n_q;
	assign seg_hi   = (lo_q + (w_q << 1) < n_q) ? lo_q + (w_q << 1) : n_q;
	assign w2       = w_q << 1;
	assign x_start  = (state_q == ST_X0);

	mch_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (x_start),
		.pa     (pa_q),
		.pb     (pb_q),
		.pc     (pc_q),
		.done   (x_done),
		.nonpos (x_nonpos)
	);

	always_comb begin
		a_we = 1'b0; a_wa = '0; a_wd = '0;
		b_we = 1'b0; b_wa = '0; b_wd = '0;
		h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
		s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
		ra0  = '0;   ra1  = '0;
		unique case (state_q)
			ST_IDLE: begin
				h_ra = AW'(req.index);
				if (req_valid && req.req_type == REQ_ADD && room) begin
					a_we = 1'b1;
					a_wa = AW'(loaded_q);
					a_wd = pt_in;
				end
			end
			ST_SRD: begin
				ra0 = AW'(i_q);
				ra1 = AW'(j_q);
			end
			ST_SCMP: begin
				if (sel_q) begin
					a_we = 1'b1;
					a_wa = AW'(k_q);
					a_wd = take_a ? src0 : src1;
				end else begin
					b_we = 1'b1;
					b_wa = AW'(k_q);
					b_wd = take_a ? src0 : src1;
				end
			end
			ST_U0: begin
				ra0  = '0;
				s_we = 1'b1;
				s_wa = '0;
				s_wd = '0;
			end
			ST_U1: begin
				ra0  = AW'(1);
				s_we = 1'b1;
				s_wa = PW'(1);
				s_wd = AW'(1);
			end
			ST_PRD: ra0 = ic_q;
			ST_SR:  s_ra = PW'(top_q - TW'(2));
			ST_SW:  ra0 = s_rd;
			ST_PUSH: begin
				s_we = 1'b1;
				s_wa = PW'(top_q);
				s_wd = ic_q;
			end
			ST_L0: begin
				ra0  = AW'(n_q - CW'(1));
				s_we = 1'b1;
				s_wa = PW'(top_q);
				s_wd = AW'(n_q - CW'(1));
			end
			ST_L1: begin
				ra0  = AW'(n_q - CW'(2));
				s_we = 1'b1;
				s_wa = PW'(base_q + TW'(1));
				s_wd = AW'(n_q - CW'(2));
			end
			ST_C0: s_ra = (TW'(k_q) < base_q) ? PW'(k_q) : PW'(k_q + CW'(1));
			ST_C1: ra0 = s_rd;
			ST_C2: begin
				h_we = 1'b1;
				h_wa = AW'(k_q);
				h_wd = src0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			loaded_q <= '0;
			hs_q     <= '0;
			ovf_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (req.req_type == REQ_READ) begin
							ok_q    <= 32'(req.index) < 32'(hs_q);
							state_q <= ST_RD;
						end else if (!req.last) begin
							loaded_q <= loaded_n;
							ovf_q    <= ovf_n;
							res_q    <= '{hull_count: 11'(hs_q), vertex_x: '0,
								vertex_y: '0, index_ok: 1'b0, status: st_n};
							state_q  <= ST_RES;
						end else begin
							loaded_q <= '0;
							ovf_q    <= 1'b0;
							if (loaded_n < HW'(2)) begin
								hs_q    <= '0;
								res_q   <= '{hull_count: '0, vertex_x: '0,
									vertex_y: '0, index_ok: 1'b0, status: STAT_FEW};
								state_q <= ST_RES;
							end else begin
								n_q     <= CW'(loaded_n);
								st_q    <= st_n;
								w_q     <= CW'(1);
								lo_q    <= '0;
								sel_q   <= 1'b0;
								state_q <= ST_SSEG;
							end
						end
					end
				end
				ST_RD: begin
					res_q.hull_count <= 11'(hs_q);
					res_q.vertex_x   <= ok_q ? 16'(h_rd[PTW-1 -: CB]) : '0;
					res_q.vertex_y   <= ok_q ? 16'(h_rd[CB-1:0]) : '0;
					res_q.index_ok   <= ok_q;
					res_q.status     <= STAT_OK;
					state_q          <= ST_RES;
				end
				ST_RES: if (res_take) state_q <= ST_IDLE;
				ST_SSEG: begin
					mid_q   <= seg_mid;
					hi_q    <= seg_hi;
					i_q     <= lo_q;
					j_q     <= seg_mid;
					k_q     <= lo_q;
					state_q <= ST_SRD;
				end
				ST_SRD: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (take_a) i_q <= i_q + CW'(1);
					else j_q <= j_q + CW'(1);
					k_q <= k_q + CW'(1);
					if (k_q + CW'(1) == hi_q) begin
						if (lo_q + w2 >= n_q) begin
							sel_q <= ~sel_q;
							w_q   <= w2;
							lo_q  <= '0;
							state_q <= (w2 >= n_q) ? ST_U0 : ST_SSEG;
						end else begin
							lo_q    <= lo_q + w2;
							state_q <= ST_SSEG;
						end
					end else begin
						state_q <= ST_SRD;
					end
				end
				ST_U0: state_q <= ST_U1;
				ST_U1: begin
					pa_q    <= src0;
					ia_q    <= '0;
					state_q <= ST_U2;
				end
				ST_U2: begin
					pb_q    <= src0;
					ib_q    <= AW'(1);
					top_q   <= TW'(2);
					base_q  <= '0;
					upper_q <= 1'b1;
					ic_q    <= AW'(2);
					state_q <= (n_q > CW'(2)) ? ST_PRD : ST_L0;
				end
				ST_PRD: state_q <= ST_PWT;
				ST_PWT: begin
					pc_q    <= src0;
					state_q <= ST_X0;
				end
				ST_X0: state_q <= ST_XW;
				ST_XW: begin
					if (x_done) begin
						if (x_nonpos) begin
							ib_q    <= ia_q;
							pb_q    <= pa_q;
							top_q   <= top_q - TW'(1);
							state_q <= (top_q - base_q >= TW'(3)) ? ST_SR : ST_PUSH;
						end else begin
							state_q <= ST_PUSH;
						end
					end
				end
				ST_SR: state_q <= ST_SW;
				ST_SW: begin
					ia_q    <= s_rd;
					state_q <= ST_PW2;
				end
				ST_PW2: begin
					pa_q    <= src0;
					state_q <= ST_X0;
				end
				ST_PUSH: begin
					ia_q  <= ib_q;
					pa_q  <= pb_q;
					ib_q  <= ic_q;
					pb_q  <= pc_q;
					top_q <= top_q + TW'(1);
					if (upper_q) begin
						if (CW'(ic_q) + CW'(1) < n_q) begin
							ic_q    <= ic_q + AW'(1);
							state_q <= ST_PRD;
						end else begin
							state_q <= ST_L0;
						end
					end else if (ic_q == '0) begin
						state_q <= ST_CS;
					end else begin
						ic_q    <= ic_q - AW'(1);
						state_q <= ST_PRD;
					end
				end
				ST_L0: begin
					base_q  <= top_q;
					state_q <= ST_L1;
				end
				ST_L1: begin
					pa_q    <= src0;
					ia_q    <= AW'(n_q - CW'(1));
					state_q <= ST_L2;
				end
				ST_L2: begin
					pb_q    <= src0;
					ib_q    <= AW'(n_q - CW'(2));
					top_q   <= base_q + TW'(2);
					upper_q <= 1'b0;
					if (n_q > CW'(2)) begin
						ic_q    <= AW'(n_q - CW'(3));
						state_q <= ST_PRD;
					end else begin
						state_q <= ST_CS;
					end
				end
				ST_CS: begin
					hs_tmp_q <= (top_q - TW'(2) > TW'(MAX_POINTS)) ? HW'(MAX_POINTS)
						: HW'(top_q - TW'(2));
					k_q      <= '0;
					state_q  <= ST_C0;
				end
				ST_C0: state_q <= ST_C1;
				ST_C1: state_q <= ST_C2;
				ST_C2: begin
					k_q <= k_q + CW'(1);
					if (k_q + CW'(1) >= CW'(hs_tmp_q)) begin
						hs_q    <= hs_tmp_q;
						res_q   <= '{hull_count: 11'(hs_tmp_q), vertex_x: '0,
							vertex_y: '0, index_ok: 1'b0, status: st_q};
						state_q <= ST_RES;
					end else begin
						state_q <= ST_C0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RES);
	assign res       = res_q;

endmodule

// ----- rtl/monotone_chain_convex_hull.sv -----
// ----------------------------------------------------------------------------
// monotone_chain_convex_hull
// Batch convex hull: load points, sort, build both chains, read vertices.
// ----------------------------------------------------------------------------
//  channel   dir  payload  handshake
//  req       in   req_t    req_valid / req_stall
//  res       out  res_t    res_valid / res_stall
//
//  Plain adds and reads (hull memory lookup) are served one request at a time.
//  A closing add runs a bottom-up merge sort that passes back and forth between
//  the two point banks, then a chain walk of orientation tests and a
//  vertex-by-vertex copy into the hull memory.
//  Reset clears counters and control; memories hold until written.
//  A result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module monotone_chain_convex_hull #(
	parameter int MAX_POINTS = mch_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = mch_pkg::COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mch_pkg::req_t req_data,
	output logic          res_valid,
	input  logic          res_stall,
	output mch_pkg::res_t res_data
);
	import mch_pkg::*;

	logic core_ready, core_valid, core_take;
	res_t core_res;
	logic out_valid_q;
	res_t out_q;

	mch_core #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req_data),
		.req_ready (core_ready),
		.res_valid (core_valid),
		.res       (core_res),
		.res_take  (core_take)
	);

	assign req_stall = ~core_ready;
	assign core_take = ~out_valid_q | ~res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_take) begin
			out_valid_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_take && core_valid) out_q <= core_res;
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the monotone chain convex hull block: point batches
// of varied shape and size are loaded, closed and read back; every result is
// predicted in the bench and compared as a whole.
// ----------------------------------------------------------------------------
module tb;
	import mch_pkg::*;

	localparam int NPTS = 1024;
	localparam int WD_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_data;

	monotone_chain_convex_hull uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hull predictor state
	logic signed [15:0] batch_x [NPTS];
	logic signed [15:0] batch_y [NPTS];
	logic signed [15:0] hull_x [NPTS];
	logic signed [15:0] hull_y [NPTS];
	int unsigned batch_len = 0;
	int unsigned hull_len = 0;
	bit batch_ovfl = 0;

	res_t expected_q[$];
	int n_mismatch = 0;
	int n_results = 0;
	int n_reqs = 0;
	int n_hulls = 0;
	bit idle_on = 1'b1;
	bit hold_rx = 1'b0;
	int rx_gap = 0;
	int quiet = 0;

	function automatic bit pt_le(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] bx, logic signed [15:0] by);
		return ax < bx || (ax == bx && ay <= by);
	endfunction

	function automatic longint turn(int a, int b, int c);
		longint abx, aby, acx, acy;
		abx = longint'(batch_x[b]) - batch_x[a];
		aby = longint'(batch_y[b]) - batch_y[a];
		acx = longint'(batch_x[c]) - batch_x[a];
		acy = longint'(batch_y[c]) - batch_y[a];
		return abx * acy - aby * acx;
	endfunction

	// sort the batch and walk both chains
	task automatic compute_hull(int n);
		logic signed [15:0] tx [NPTS];
		logic signed [15:0] ty [NPTS];
		int stk [2*NPTS];
		int w, lo, mid, hi, i, j, k, up, len;
		for (w = 1; w < n; w *= 2) begin
			for (lo = 0; lo < n; lo += 2*w) begin
				mid = (lo + w < n) ? lo + w : n;
				hi = (lo + 2*w < n) ? lo + 2*w : n;
				i = lo; j = mid; k = lo;
				while (i < mid && j < hi) begin
					if (pt_le(batch_x[i], batch_y[i], batch_x[j], batch_y[j])) begin
						tx[k] = batch_x[i]; ty[k] = batch_y[i]; i++;
					end else begin
						tx[k] = batch_x[j]; ty[k] = batch_y[j]; j++;
					end
					k++;
				end
				while (i < mid) begin tx[k] = batch_x[i]; ty[k] = batch_y[i]; i++; k++; end
				while (j < hi) begin tx[k] = batch_x[j]; ty[k] = batch_y[j]; j++; k++; end
			end
			for (i = 0; i < n; i++) begin batch_x[i] = tx[i]; batch_y[i] = ty[i]; end
		end
		stk[0] = 0; stk[1] = 1; len = 2;
		for (i = 2; i < n; i++) begin
			stk[len++] = i;
			while (len > 2 && turn(stk[len-3], stk[len-2], stk[len-1]) <= 0) begin
				stk[len-2] = stk[len-1]; len--;
			end
		end
		up = len;
		stk[up] = n - 1; stk[up+1] = n - 2; len = 2;
		for (i = n - 2; i > 0; i--) begin
			stk[up+len] = i - 1; len++;
			while (len > 2 && turn(stk[up+len-3], stk[up+len-2], stk[up+len-1]) <= 0) begin
				stk[up+len-2] = stk[up+len-1]; len--;
			end
		end
		for (k = 0; k < len - 2; k++) stk[up+k] = stk[up+k+1];
		hull_len = up + len - 2;
		if (hull_len > NPTS) hull_len = NPTS;
		for (k = 0; k < hull_len; k++) begin
			hull_x[k] = batch_x[stk[k] % NPTS];
			hull_y[k] = batch_y[stk[k] % NPTS];
		end
	endtask

	task automatic predict_result(req_t r);
		res_t e;
		e = '0;
		if (r.req_type == REQ_ADD) begin
			if (batch_len < NPTS) begin
				batch_x[batch_len] = r.x; batch_y[batch_len] = r.y; batch_len++;
			end else batch_ovfl = 1;
			e.status = batch_ovfl ? STAT_OVFL : STAT_OK;
			if (r.last) begin
				if (batch_len < 2) begin
					hull_len = 0; e.status = STAT_FEW;
				end else begin
					compute_hull(batch_len); n_hulls++;
				end
				batch_len = 0; batch_ovfl = 0;
			end
		end else if (r.index < hull_len) begin
			e.index_ok = 1'b1;
			e.vertex_x = hull_x[r.index];
			e.vertex_y = hull_y[r.index];
		end
		e.hull_count = hull_len[10:0];
		expected_q.push_back(e);
	endtask

	task automatic send(req_t r);
		int g;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			g = $urandom_range(1, 15);
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		predict_result(r);
		n_reqs++;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic add_pt(logic signed [15:0] px, logic signed [15:0] py, bit lst);
		req_t r;
		r = '0;
		r.req_type = REQ_ADD; r.x = px; r.y = py; r.last = lst;
		r.index = 10'($urandom);
		send(r);
	endtask

	task automatic read_v(logic [9:0] idx);
		req_t r;
		r = '0;
		r.req_type = REQ_READ; r.index = idx;
		r.x = 16'($urandom); r.y = 16'($urandom); r.last = 1'($urandom);
		send(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic read_hull();
		int k;
		for (k = 0; k <= hull_len && k < NPTS; k++) read_v(10'(k));
		read_v(10'($urandom));
	endtask

	// random batch of points with coordinates from a chosen spread
	task automatic rand_batch(int n, int spread);
		int k;
		logic signed [15:0] px, py;
		for (k = 0; k < n; k++) begin
			case (spread)
				0: begin px = 16'($urandom_range(0, 6) - 3); py = 16'($urandom_range(0, 6) - 3); end
				1: begin px = 16'($urandom_range(0, 400) - 200); py = 16'($urandom_range(0, 400) - 200); end
				2: begin px = 16'($urandom_range(0, 8) * 100); py = 16'(px * 2 + 5); end
				default: begin px = 16'($urandom); py = 16'($urandom); end
			endcase
			add_pt(px, py, k == n - 1);
		end
	endtask

	task automatic test_directed();
		add_pt(16'sd5, 16'sd5, 1'b1);
		read_v(10'd0);
		add_pt(-16'sd32768, -16'sd32768, 1'b0);
		add_pt(16'sd32767, -16'sd32768, 1'b0);
		add_pt(16'sd32767, 16'sd32767, 1'b0);
		add_pt(-16'sd32768, 16'sd32767, 1'b0);
		add_pt(16'sd0, 16'sd0, 1'b0);
		add_pt(16'sd32767, 16'sd32767, 1'b1);
		read_hull();
		read_v(10'd1023);
		add_pt(16'sd1, 16'sd1, 1'b0);
		add_pt(16'sd2, 16'sd2, 1'b0);
		add_pt(16'sd3, 16'sd3, 1'b1);
		read_hull();
		add_pt(16'sd7, -16'sd7, 1'b0);
		add_pt(16'sd7, -16'sd7, 1'b1);
		read_v(10'd0);
		drain();
	endtask

	task automatic test_overflow();
		int k;
		for (k = 0; k < NPTS + 3; k++)
			add_pt(16'($urandom_range(0, 60) - 30), 16'($urandom_range(0, 60) - 30),
				k == NPTS + 2);
		read_hull();
		add_pt(16'sd1, 16'sd1, 1'b1);
		drain();
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_rx = 1'b1;
				repeat (300) @(posedge clk);
				hold_rx = 1'b0;
			end
			rand_batch(8, 1);
		join
		read_hull();
		drain();
	endtask

	task automatic test_random(int stop_at, bit idles);
		idle_on = idles;
		while (n_reqs < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1)) read_v(10'($urandom));
				else add_pt(16'($urandom), 16'($urandom), 1'($urandom));
			end else begin
				rand_batch($urandom_range(1, 24), $urandom_range(0, 3));
				read_hull();
			end
		end
		drain();
	endtask

	// receiver stall
	always @(posedge clk) begin
		if (hold_rx) begin
			res_stall <= 1'b1;
		end else if (rx_gap != 0) begin
			rx_gap <= rx_gap - 1;
			res_stall <= (rx_gap != 1);
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			res_stall <= 1'b1;
			rx_gap <= $urandom_range(1, 15);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		res_t e;
		if (arst_n && res_valid && !res_stall) begin
			n_results++;
			if (expected_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10) $display("unexpected result %p", res_data);
			end else begin
				e = expected_q.pop_front();
				if (res_data !== e) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: expected %p got %p", e, res_data);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WD_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_backpressure();
		test_random(1700, 1'b1);
		test_random(1950, 1'b0);
		repeat (50) @(posedge clk);
		$display("Ran %0d requests, %0d results, %0d hulls built, including overflow and",
			n_reqs, n_results, n_hulls);
		$display("degenerate batches under random idling and a long output hold.");
		if (n_mismatch == 0 && expected_q.size() == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/mch_pkg.sv
rtl/mch_cross.sv
rtl/mch_core.sv
rtl/monotone_chain_convex_hull.sv
tb/sv/tb.sv
